[hw/rtl/ldf_pkg.sv]
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; used by ldf_parse, ldf_out_reg and length_prefixed_deframer.
`default_nettype none

package ldf_pkg;

    // Header is four length bytes followed by one opcode byte
    localparam int unsigned HEADER_BYTES = 5;
    localparam int unsigned HDR_CNT_W    = 3;
    localparam int unsigned LEN_W        = 32;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned CFG_DATA_W   = 32;

    // Last length byte position, opcode comes next
    localparam logic [HDR_CNT_W-1:0] HDR_LAST_LEN = 3'(HEADER_BYTES - 2);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_LEN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_BIG_ENDIAN = 2'd1;

    // Reset values of the configuration registers
    localparam logic [LEN_W-1:0] MAX_LEN_RESET    = 32'd1048576;
    localparam logic             BIG_ENDIAN_RESET = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0] max_payload_len;
        logic             length_big_endian;
    } ldf_cfg_t;

    // One result word
    typedef struct packed {
        logic [BYTE_W-1:0] frame_op;
        logic [BYTE_W-1:0] payload_byte;
        logic              has_data;
        logic              last_of_frame;
        logic              link_failed;
    } ldf_result_t;

endpackage

`default_nettype wire

[hw/rtl/ldf_parse.sv]
// Frame parser: header position, length assembly, payload countdown, sticky failure.
// Depends on ldf_pkg.
`default_nettype none

module ldf_parse (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [ldf_pkg::BYTE_W-1:0]  in_byte,
    input  wire ldf_pkg::ldf_cfg_t           cfg,
    output logic                             res_valid,
    output ldf_pkg::ldf_result_t             res
);

    logic [ldf_pkg::HDR_CNT_W-1:0] header_count_reg, header_count_next;
    logic [ldf_pkg::LEN_W-1:0]     length_accum_reg, length_accum_next;
    logic [ldf_pkg::BYTE_W-1:0]    current_op_reg, current_op_next;
    logic [ldf_pkg::LEN_W-1:0]     bytes_remaining_reg, bytes_remaining_next;
    logic                          in_payload_reg, in_payload_next;
    logic                          failed_flag_reg, failed_flag_next;

    logic [ldf_pkg::LEN_W-1:0]     accum_base;
    logic [ldf_pkg::LEN_W-1:0]     accum_le;

    // Little-endian lane insert, accumulator starts clean on the first byte
    always_comb
    begin
        accum_base = (header_count_reg == '0) ? '0 : length_accum_reg;
        accum_le   = accum_base;
        case (header_count_reg[1:0])
            2'd0:    accum_le[7:0]   = in_byte;
            2'd1:    accum_le[15:8]  = in_byte;
            2'd2:    accum_le[23:16] = in_byte;
            2'd3:    accum_le[31:24] = in_byte;
            default: accum_le        = accum_base;
        endcase
    end

    // Next state and result for the word being processed
    always_comb
    begin
        header_count_next    = header_count_reg;
        length_accum_next    = length_accum_reg;
        current_op_next      = current_op_reg;
        bytes_remaining_next = bytes_remaining_reg;
        in_payload_next      = in_payload_reg;
        failed_flag_next     = failed_flag_reg;
        res_valid            = 1'b0;
        res                  = '0;

        if (step && !failed_flag_reg)
        begin
            if (in_payload_reg)
            begin
                bytes_remaining_next = bytes_remaining_reg - 1'b1;
                res_valid            = 1'b1;
                res.frame_op         = current_op_reg;
                res.payload_byte     = in_byte;
                res.has_data         = 1'b1;
                if (bytes_remaining_reg == ldf_pkg::LEN_W'(1))
                begin
                    res.last_of_frame = 1'b1;
                    in_payload_next   = 1'b0;
                    header_count_next = '0;
                end
            end
            else if (header_count_reg <= ldf_pkg::HDR_LAST_LEN)
            begin
                if (cfg.length_big_endian)
                    length_accum_next = {accum_base[ldf_pkg::LEN_W-ldf_pkg::BYTE_W-1:0],
                                         in_byte};
                else
                    length_accum_next = accum_le;
                header_count_next = header_count_reg + 1'b1;
            end
            else
            begin
                // Opcode word: header complete, check length
                current_op_next   = in_byte;
                header_count_next = '0;
                if (length_accum_reg > cfg.max_payload_len)
                begin
                    failed_flag_next  = 1'b1;
                    res_valid         = 1'b1;
                    res.frame_op      = in_byte;
                    res.last_of_frame = 1'b1;
                    res.link_failed   = 1'b1;
                end
                else if (length_accum_reg == '0)
                begin
                    res_valid         = 1'b1;
                    res.frame_op      = in_byte;
                    res.last_of_frame = 1'b1;
                end
                else
                begin
                    bytes_remaining_next = length_accum_reg;
                    in_payload_next      = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg    <= '0;
            length_accum_reg    <= '0;
            current_op_reg      <= '0;
            bytes_remaining_reg <= '0;
            in_payload_reg      <= 1'b0;
            failed_flag_reg     <= 1'b0;
        end
        else
        begin
            header_count_reg    <= header_count_next;
            length_accum_reg    <= length_accum_next;
            current_op_reg      <= current_op_next;
            bytes_remaining_reg <= bytes_remaining_next;
            in_payload_reg      <= in_payload_next;
            failed_flag_reg     <= failed_flag_next;
        end
    end

    // Header counter never passes the opcode position
    a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
        header_count_reg <= ldf_pkg::HDR_CNT_W'(ldf_pkg::HEADER_BYTES - 1))
        else $error("header count out of range");

    // While passing payload there is always at least one byte left
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (bytes_remaining_reg != '0))
        else $error("payload active with zero count");

    // Once failed, the parser stays failed and produces nothing
    a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        failed_flag_reg |=> (failed_flag_reg && !res_valid))
        else $error("failure flag cleared or result after failure");

endmodule

`default_nettype wire

[hw/rtl/ldf_out_reg.sv]
// Output result register with valid/stall handshake.
// Depends on ldf_pkg.
`default_nettype none

module ldf_out_reg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire ldf_pkg::ldf_result_t load_data,
    input  wire logic                 out_stall,
    output logic                      room,
    output logic                      out_valid,
    output ldf_pkg::ldf_result_t      out_data
);

    logic                 vld_reg, vld_next;
    ldf_pkg::ldf_result_t data_reg;

    // Register can take a word when empty or when its word leaves this cycle
    assign room     = !vld_reg || !out_stall;
    assign vld_next = room ? load : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // Payload register, no reset needed
    always_ff @(posedge clk)
    begin
        if (room && load)
            data_reg <= load_data;
    end

    assign out_valid = vld_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

[hw/rtl/length_prefixed_deframer.sv]
// Each input word is first registered in the input register; its result is then registered
// in the output register. Throughput: one byte per cycle while the output is not stalled; while
// a result waits under stall, the input register holds one word and stalls the input.
// Reset (rst_n low, asynchronous): parser returns to the first header byte,
// failure clears, config returns to max length 1048576 and big-endian length.
// Top level: input register, config registers, parser and output register.
// Depends on ldf_pkg, ldf_parse, ldf_out_reg.
`default_nettype none

module length_prefixed_deframer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // input channel
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [ldf_pkg::BYTE_W-1:0]      rx_byte,
    // output channel
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [ldf_pkg::BYTE_W-1:0]           frame_op,
    output logic [ldf_pkg::BYTE_W-1:0]           payload_byte,
    output logic                                 has_data,
    output logic                                 last_of_frame,
    output logic                                 link_failed,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ldf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ldf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic                       in_vld_reg;
    logic [ldf_pkg::BYTE_W-1:0] in_byte_reg;
    ldf_pkg::ldf_cfg_t          cfg_reg;
    logic                       room;
    logic                       step;
    logic                       res_valid;
    ldf_pkg::ldf_result_t       res;
    ldf_pkg::ldf_result_t       out_data;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_payload_len   <= ldf_pkg::MAX_LEN_RESET;
            cfg_reg.length_big_endian <= ldf_pkg::BIG_ENDIAN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ldf_pkg::CFG_MAX_PAYLOAD_LEN:
                    cfg_reg.max_payload_len <= cfg_data;
                ldf_pkg::CFG_LENGTH_BIG_ENDIAN:
                    cfg_reg.length_big_endian <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Input register: holds a word until the output side has room
    assign step     = in_vld_reg && room;
    assign in_stall = in_vld_reg && !room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_byte_reg <= rx_byte;
    end

    ldf_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .in_byte   (in_byte_reg),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    ldf_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_data (res),
        .out_stall (out_stall),
        .room      (room),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign frame_op      = out_data.frame_op;
    assign payload_byte  = out_data.payload_byte;
    assign has_data      = out_data.has_data;
    assign last_of_frame = out_data.last_of_frame;
    assign link_failed   = out_data.link_failed;

    // Error word is always an end-of-frame word with no data
    a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && link_failed) |-> (last_of_frame && !has_data && payload_byte == '0))
        else $error("malformed error word");

    // Nothing follows the error word once it is taken
    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && link_failed) |=> !out_valid)
        else $error("word after error word");

    // A word in the input register is stalled only while the output is full
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
